/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RJ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RJ_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define RJ_ASSERT(lbl, clk, rst_n, prop)
`define RJ_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

/* src/rej_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rej_pkg
// shared constants, types and saturation helper for the jacobian pipeline
// ----------------------------------------------------------------------------
package rej_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;
    localparam int MAX_W         = 64;
    localparam int CFG_IDX_BITS  = 2;

    typedef logic signed [MAX_W+1:0] t_sum;
    typedef logic signed [MAX_W:0]   t_wide;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_OBS_U = 2'd0,
        CFG_OBS_V = 2'd1
    } t_cfg_idx;

    // clip a widened sum to a w-bit two's complement range
    function automatic t_wide sat_to(input t_sum v, input int w);
        t_sum hi;
        t_sum lo;
        hi = (t_sum'(1) <<< (w - 1)) - t_sum'(1);
        lo = -hi - t_sum'(1);
        if (v > hi) begin
            sat_to = t_wide'(hi);
        end else if (v < lo) begin
            sat_to = t_wide'(lo);
        end else begin
            sat_to = t_wide'(v);
        end
    endfunction

endpackage

/* src/rej_fmul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rej_fmul
// fixed point multiply, floor rounding, saturated to the word
// ----------------------------------------------------------------------------
module rej_fmul #(
    parameter int W = rej_pkg::DEF_WORD_BITS,
    parameter int F = rej_pkg::DEF_FRAC_BITS
) (
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [W-1:0] o_y
);
    import rej_pkg::*;

    localparam logic signed [2*W-1:0] PMAX = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [2*W-1:0] PMIN = ~PMAX;

    logic signed [2*W-1:0] prod;
    logic signed [2*W-1:0] shifted;

    assign prod    = (2*W)'(i_a) * (2*W)'(i_b);
    // arithmetic shift of the exact product rounds toward minus infinity
    assign shifted = prod >>> F;

    always_comb begin
        if (shifted > PMAX) begin
            o_y = {1'b0, {(W-1){1'b1}}};
        end else if (shifted < PMIN) begin
            o_y = {1'b1, {(W-1){1'b0}}};
        end else begin
            o_y = shifted[W-1:0];
        end
    end

endmodule

/* src/rej_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rej_front
// five stages: offset, quaternion products, rotation, R^T d products, Cp sums
// ----------------------------------------------------------------------------
module rej_front #(
    parameter int W = rej_pkg::DEF_WORD_BITS,
    parameter int F = rej_pkg::DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_pos  [3],
    input  logic signed [W-1:0] i_quat [4],
    input  logic signed [W-1:0] i_pt   [3],
    output logic                o_valid,
    output logic signed [W-1:0] o_cp   [3],
    output logic signed [W-1:0] o_rot  [3][3]
);
    import rej_pkg::*;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] ONE  = (F >= W - 1) ? WMAX : (W'(1) << F);

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        sadd = W'(sat_to(t_sum'(a) + t_sum'(b), W));
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        ssub = W'(sat_to(t_sum'(a) - t_sum'(b), W));
    endfunction

    logic                r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [W-1:0] r1_d [3];
    logic signed [W-1:0] r1_tq [3];
    logic signed [W-1:0] r1_q [4];
    logic signed [W-1:0] r2_m [9];
    logic signed [W-1:0] r2_d [3];
    logic signed [W-1:0] r3_rot [3][3];
    logic signed [W-1:0] r3_d [3];
    logic signed [W-1:0] r4_m [3][3];
    logic signed [W-1:0] r4_rot [3][3];
    logic signed [W-1:0] r5_cp [3];
    logic signed [W-1:0] r5_rot [3][3];

    logic signed [W-1:0] n1_d [3];
    logic signed [W-1:0] n1_tq [3];
    logic signed [W-1:0] m2_a [9];
    logic signed [W-1:0] m2_b [9];
    logic signed [W-1:0] n2_m [9];
    logic signed [W-1:0] n3_rot [3][3];
    logic signed [W-1:0] n4_m [3][3];
    logic signed [W-1:0] n5_cp [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: offset to the camera and doubled quaternion
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_d[i]  = ssub(i_pt[i], i_pos[i]);
            n1_tq[i] = sadd(i_quat[i], i_quat[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_d  <= n1_d;
            r1_tq <= n1_tq;
            r1_q  <= i_quat;
        end
    end

    // stage 2: twx twy twz txx txy txz tyy tyz tzz
    always_comb begin
        m2_a[0] = r1_tq[0]; m2_b[0] = r1_q[3];
        m2_a[1] = r1_tq[1]; m2_b[1] = r1_q[3];
        m2_a[2] = r1_tq[2]; m2_b[2] = r1_q[3];
        m2_a[3] = r1_tq[0]; m2_b[3] = r1_q[0];
        m2_a[4] = r1_tq[1]; m2_b[4] = r1_q[0];
        m2_a[5] = r1_tq[2]; m2_b[5] = r1_q[0];
        m2_a[6] = r1_tq[1]; m2_b[6] = r1_q[1];
        m2_a[7] = r1_tq[2]; m2_b[7] = r1_q[1];
        m2_a[8] = r1_tq[2]; m2_b[8] = r1_q[2];
    end

    for (genvar k = 0; k < 9; k++) begin : g_qmul
        rej_fmul #(.W(W), .F(F)) u_mul (.i_a(m2_a[k]), .i_b(m2_b[k]), .o_y(n2_m[k]));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_m <= n2_m;
            r2_d <= r1_d;
        end
    end

    // stage 3: rotation matrix
    always_comb begin
        n3_rot[0][0] = ssub(ONE, sadd(r2_m[6], r2_m[8]));
        n3_rot[0][1] = ssub(r2_m[4], r2_m[2]);
        n3_rot[0][2] = sadd(r2_m[5], r2_m[1]);
        n3_rot[1][0] = sadd(r2_m[4], r2_m[2]);
        n3_rot[1][1] = ssub(ONE, sadd(r2_m[3], r2_m[8]));
        n3_rot[1][2] = ssub(r2_m[7], r2_m[0]);
        n3_rot[2][0] = ssub(r2_m[5], r2_m[1]);
        n3_rot[2][1] = sadd(r2_m[7], r2_m[0]);
        n3_rot[2][2] = ssub(ONE, sadd(r2_m[3], r2_m[6]));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_rot <= n3_rot;
            r3_d   <= r2_d;
        end
    end

    // stage 4: R[j][i] * d[j]
    for (genvar j = 0; j < 3; j++) begin : g_row
        for (genvar i = 0; i < 3; i++) begin : g_col
            rej_fmul #(.W(W), .F(F)) u_mul (
                .i_a(r3_rot[j][i]), .i_b(r3_d[j]), .o_y(n4_m[j][i])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_m   <= n4_m;
            r4_rot <= r3_rot;
        end
    end

    // stage 5: camera frame point, summed in row order
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_cp[i] = sadd(sadd(r4_m[0][i], r4_m[1][i]), r4_m[2][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_cp  <= n5_cp;
            r5_rot <= r4_rot;
        end
    end

    assign o_valid = r_v5;
    assign o_cp    = r5_cp;
    assign o_rot   = r5_rot;

endmodule

/* src/rej_recip.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rej_recip
// pipelined restoring divider for 2^(2F) / z, one quotient bit per stage
// ----------------------------------------------------------------------------
module rej_recip #(
    parameter int W  = rej_pkg::DEF_WORD_BITS,
    parameter int F  = rej_pkg::DEF_FRAC_BITS,
    parameter int PW = 12 * rej_pkg::DEF_WORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_z,
    input  logic [PW-1:0]       i_payload,
    output logic                o_valid,
    output logic signed [W-1:0] o_iz,
    output logic                o_bad,
    output logic [PW-1:0]       o_payload
);
    import rej_pkg::*;

    localparam int N  = 2 * F + 1;
    localparam int QW = 2 * F + 1;
    localparam int CW = ((QW > W) ? QW : W) + 1;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};

    logic          r_vld  [N];
    logic [W:0]    r_rem  [N];
    logic [QW-1:0] r_quo  [N];
    logic [W-1:0]  r_den  [N];
    logic          r_neg  [N];
    logic          r_zero [N];
    logic [PW-1:0] r_pay  [N];

    logic                r_ov;
    logic signed [W-1:0] r_oiz;
    logic                r_obad;
    logic [PW-1:0]       r_opay;

    logic [W-1:0] in_mag;

    assign in_mag = i_z[W-1] ? W'(-i_z) : W'(i_z);

    for (genvar k = 0; k < N; k++) begin : g_step
        logic          p_vld;
        logic [W:0]    p_rem;
        logic [QW-1:0] p_quo;
        logic [W-1:0]  p_den;
        logic          p_neg;
        logic          p_zero;
        logic [PW-1:0] p_pay;
        logic [W:0]    sh;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_quo  = '0;
            assign p_den  = in_mag;
            assign p_neg  = i_z[W-1];
            assign p_zero = (i_z == '0);
            assign p_pay  = i_payload;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_den  = r_den[k-1];
            assign p_neg  = r_neg[k-1];
            assign p_zero = r_zero[k-1];
            assign p_pay  = r_pay[k-1];
        end

        // dividend is a single one at the top bit
        assign sh = {p_rem[W-1:0], ((k == 0) ? 1'b1 : 1'b0)};
        assign ge = (sh >= {1'b0, p_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= ge ? (sh - {1'b0, p_den}) : sh;
                r_quo[k]  <= {p_quo[QW-2:0], ge};
                r_den[k]  <= p_den;
                r_neg[k]  <= p_neg;
                r_zero[k] <= p_zero;
                r_pay[k]  <= p_pay;
            end
        end
    end

    logic [CW-1:0]       quo_ext;
    logic [CW-1:0]       lim;
    logic [W-1:0]        mag;
    logic signed [W-1:0] n_iz;
    logic                n_bad;

    always_comb begin
        quo_ext = CW'(r_quo[N-1]);
        lim     = r_neg[N-1] ? (CW'(1) << (W - 1)) : ((CW'(1) << (W - 1)) - CW'(1));
        n_bad   = 1'b0;
        mag     = W'(quo_ext);
        if (quo_ext > lim) begin
            n_bad = 1'b1;
            mag   = W'(lim);
        end
        n_iz = r_neg[N-1] ? W'(-mag) : W'(mag);
        if (r_zero[N-1]) begin
            n_bad = 1'b1;
            n_iz  = WMAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_adv) begin
            r_ov <= r_vld[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_oiz  <= n_iz;
            r_obad <= n_bad;
            r_opay <= r_pay[N-1];
        end
    end

    assign o_valid   = r_ov;
    assign o_iz      = r_oiz;
    assign o_bad     = r_obad;
    assign o_payload = r_opay;

endmodule

/* src/rej_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rej_back
// four stages: projection, depth term, jacobian products, row sums
// ----------------------------------------------------------------------------
module rej_back #(
    parameter int W = rej_pkg::DEF_WORD_BITS,
    parameter int F = rej_pkg::DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_iz,
    input  logic                i_bad,
    input  logic signed [W-1:0] i_cp   [3],
    input  logic signed [W-1:0] i_rot  [3][3],
    input  logic signed [W-1:0] i_obs  [2],
    output logic                o_valid,
    output logic                o_bad,
    output logic signed [W-1:0] o_res  [2],
    output logic signed [W-1:0] o_dpos [2][3],
    output logic signed [W-1:0] o_drot [2][3],
    output logic signed [W-1:0] o_dpt  [2][3]
);
    import rej_pkg::*;

    localparam logic signed [W-1:0] ZERO = '0;

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        sadd = W'(sat_to(t_sum'(a) + t_sum'(b), W));
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        ssub = W'(sat_to(t_sum'(a) - t_sum'(b), W));
    endfunction

    logic r_v1, r_v2, r_v3, r_v4;

    // stage 1 products
    logic signed [W-1:0] n1_pu, n1_pv, n1_zc;
    logic signed [W-1:0] n1_ra [3];
    logic signed [W-1:0] n1_rb [3];
    logic signed [W-1:0] r1_pu, r1_pv, r1_zc, r1_iz, r1_c0, r1_c1;
    logic signed [W-1:0] r1_ra [3];
    logic signed [W-1:0] r1_rb [3];
    logic signed [W-1:0] r1_r2 [3];
    logic                r1_bad;

    rej_fmul #(.W(W), .F(F)) u_pu (.i_a(i_cp[0]), .i_b(i_iz), .o_y(n1_pu));
    rej_fmul #(.W(W), .F(F)) u_pv (.i_a(i_cp[1]), .i_b(i_iz), .o_y(n1_pv));
    rej_fmul #(.W(W), .F(F)) u_zc (.i_a(i_iz), .i_b(i_cp[2]), .o_y(n1_zc));

    for (genvar i = 0; i < 3; i++) begin : g_izr
        rej_fmul #(.W(W), .F(F)) u_ra (.i_a(i_iz), .i_b(i_rot[i][0]), .o_y(n1_ra[i]));
        rej_fmul #(.W(W), .F(F)) u_rb (.i_a(i_iz), .i_b(i_rot[i][1]), .o_y(n1_rb[i]));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_pu  <= n1_pu;
            r1_pv  <= n1_pv;
            r1_zc  <= n1_zc;
            r1_ra  <= n1_ra;
            r1_rb  <= n1_rb;
            r1_iz  <= i_iz;
            r1_c0  <= i_cp[0];
            r1_c1  <= i_cp[1];
            r1_bad <= i_bad;
            for (int i = 0; i < 3; i++) begin
                r1_r2[i] <= i_rot[i][2];
            end
        end
    end

    // stage 2: third H column, -proj/z
    logic signed [W-1:0] m2_u, m2_v;
    logic signed [W-1:0] r2_hu, r2_hv, r2_pu, r2_pv, r2_zc, r2_c0, r2_c1;
    logic signed [W-1:0] r2_ra [3];
    logic signed [W-1:0] r2_rb [3];
    logic signed [W-1:0] r2_r2 [3];
    logic                r2_bad;

    rej_fmul #(.W(W), .F(F)) u_hu (.i_a(r1_pu), .i_b(r1_iz), .o_y(m2_u));
    rej_fmul #(.W(W), .F(F)) u_hv (.i_a(r1_pv), .i_b(r1_iz), .o_y(m2_v));

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_hu  <= ssub(ZERO, m2_u);
            r2_hv  <= ssub(ZERO, m2_v);
            r2_pu  <= r1_pu;
            r2_pv  <= r1_pv;
            r2_zc  <= r1_zc;
            r2_c0  <= r1_c0;
            r2_c1  <= r1_c1;
            r2_ra  <= r1_ra;
            r2_rb  <= r1_rb;
            r2_r2  <= r1_r2;
            r2_bad <= r1_bad;
        end
    end

    // stage 3: products with the depth term
    logic signed [W-1:0] n3_ur [3];
    logic signed [W-1:0] n3_vr [3];
    logic signed [W-1:0] n3_uc0, n3_uc1, n3_vc0, n3_vc1;
    logic signed [W-1:0] r3_ur [3];
    logic signed [W-1:0] r3_vr [3];
    logic signed [W-1:0] r3_ra [3];
    logic signed [W-1:0] r3_rb [3];
    logic signed [W-1:0] r3_uc0, r3_uc1, r3_vc0, r3_vc1, r3_pu, r3_pv, r3_zc;
    logic                r3_bad;

    for (genvar i = 0; i < 3; i++) begin : g_hr
        rej_fmul #(.W(W), .F(F)) u_ur (.i_a(r2_hu), .i_b(r2_r2[i]), .o_y(n3_ur[i]));
        rej_fmul #(.W(W), .F(F)) u_vr (.i_a(r2_hv), .i_b(r2_r2[i]), .o_y(n3_vr[i]));
    end

    rej_fmul #(.W(W), .F(F)) u_uc0 (.i_a(r2_hu), .i_b(r2_c0), .o_y(n3_uc0));
    rej_fmul #(.W(W), .F(F)) u_uc1 (.i_a(r2_hu), .i_b(r2_c1), .o_y(n3_uc1));
    rej_fmul #(.W(W), .F(F)) u_vc0 (.i_a(r2_hv), .i_b(r2_c0), .o_y(n3_vc0));
    rej_fmul #(.W(W), .F(F)) u_vc1 (.i_a(r2_hv), .i_b(r2_c1), .o_y(n3_vc1));

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_ur  <= n3_ur;
            r3_vr  <= n3_vr;
            r3_uc0 <= n3_uc0;
            r3_uc1 <= n3_uc1;
            r3_vc0 <= n3_vc0;
            r3_vc1 <= n3_vc1;
            r3_ra  <= r2_ra;
            r3_rb  <= r2_rb;
            r3_pu  <= r2_pu;
            r3_pv  <= r2_pv;
            r3_zc  <= r2_zc;
            r3_bad <= r2_bad;
        end
    end

    // stage 4: both rows, held until the v row leaves
    logic signed [W-1:0] n4_au [3];
    logic signed [W-1:0] n4_av [3];
    logic signed [W-1:0] r4_res [2];
    logic signed [W-1:0] r4_dpos [2][3];
    logic signed [W-1:0] r4_drot [2][3];
    logic signed [W-1:0] r4_dpt [2][3];
    logic                r4_bad;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_au[i] = sadd(r3_ra[i], r3_ur[i]);
            n4_av[i] = sadd(r3_rb[i], r3_vr[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_res[0]     <= ssub(r3_pu, i_obs[0]);
            r4_res[1]     <= ssub(r3_pv, i_obs[1]);
            r4_drot[0][0] <= ssub(ZERO, r3_uc1);
            r4_drot[0][1] <= ssub(r3_uc0, r3_zc);
            r4_drot[0][2] <= r3_pv;
            r4_drot[1][0] <= ssub(r3_zc, r3_vc1);
            r4_drot[1][1] <= r3_vc0;
            r4_drot[1][2] <= ssub(ZERO, r3_pu);
            for (int i = 0; i < 3; i++) begin
                r4_dpt[0][i]  <= n4_au[i];
                r4_dpt[1][i]  <= n4_av[i];
                r4_dpos[0][i] <= ssub(ZERO, n4_au[i]);
                r4_dpos[1][i] <= ssub(ZERO, n4_av[i]);
            end
            r4_bad <= r3_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;
    assign o_bad   = r4_bad;
    assign o_res   = r4_res;
    assign o_dpos  = r4_dpos;
    assign o_drot  = r4_drot;
    assign o_dpt   = r4_dpt;

endmodule

/* src/reprojection_error_jacobian.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reprojection_error_jacobian
// residual and pose/point jacobian rows of one landmark seen by one camera
// ----------------------------------------------------------------------------
// input channel: one beat carries a pose (position, quaternion) and a world
//   point; it is taken when i_in_valid is high and o_in_stall is low
// output channel: each input beat yields two beats, the u row then the v row
//   (o_last_row high), taken when o_out_valid is high and i_out_stall is low
// order: the u row of each item leaves first, the v row once the u row beat
//   is taken; fields are Q16.16 at the default FRAC_BITS and WORD_BITS
// pacing: each item's two output beats set the input rate, as the pipeline
//   advances only when the output stage is empty or its v row is taken; the
//   bit-per-stage reciprocal divider of 2*FRAC_BITS+1 stages never limits it
// configuration: obs_u (index 0) and obs_v (index 1) are written through
//   i_cfg_we/i_cfg_idx/i_cfg_data, by the user only while the block is empty
//   (the block does not enforce this); other indexes are ignored
// reset: synchronous, clears all valid bits and both observations to zero
// stall: a stalled output beat holds; the whole pipeline freezes while the
//   output stage is full and cannot drain, and o_in_stall rises with it
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module reprojection_error_jacobian #(
    parameter int WORD_BITS = rej_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = rej_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rej_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [WORD_BITS-1:0]              i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [WORD_BITS-1:0]       i_pos_x,
    input  logic signed [WORD_BITS-1:0]       i_pos_y,
    input  logic signed [WORD_BITS-1:0]       i_pos_z,
    input  logic signed [WORD_BITS-1:0]       i_quat_x,
    input  logic signed [WORD_BITS-1:0]       i_quat_y,
    input  logic signed [WORD_BITS-1:0]       i_quat_z,
    input  logic signed [WORD_BITS-1:0]       i_quat_w,
    input  logic signed [WORD_BITS-1:0]       i_point_x,
    input  logic signed [WORD_BITS-1:0]       i_point_y,
    input  logic signed [WORD_BITS-1:0]       i_point_z,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_last_row,
    output logic                              o_bad_depth,
    output logic signed [WORD_BITS-1:0]       o_residual,
    output logic signed [WORD_BITS-1:0]       o_d_pos_x,
    output logic signed [WORD_BITS-1:0]       o_d_pos_y,
    output logic signed [WORD_BITS-1:0]       o_d_pos_z,
    output logic signed [WORD_BITS-1:0]       o_d_rot_x,
    output logic signed [WORD_BITS-1:0]       o_d_rot_y,
    output logic signed [WORD_BITS-1:0]       o_d_rot_z,
    output logic signed [WORD_BITS-1:0]       o_d_point_x,
    output logic signed [WORD_BITS-1:0]       o_d_point_y,
    output logic signed [WORD_BITS-1:0]       o_d_point_z
);
    import rej_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int PW = 12 * WORD_BITS;

    logic signed [W-1:0] r_obs_u;
    logic signed [W-1:0] r_obs_v;
    logic                r_row;
    logic                adv;
    logic                out_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_u <= '0;
            r_obs_v <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OBS_U: r_obs_u <= i_cfg_data;
                CFG_OBS_V: r_obs_v <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [W-1:0] in_pos  [3];
    logic signed [W-1:0] in_quat [4];
    logic signed [W-1:0] in_pt   [3];

    assign in_pos  = '{i_pos_x, i_pos_y, i_pos_z};
    assign in_quat = '{i_quat_x, i_quat_y, i_quat_z, i_quat_w};
    assign in_pt   = '{i_point_x, i_point_y, i_point_z};

    logic                f_valid;
    logic signed [W-1:0] f_cp  [3];
    logic signed [W-1:0] f_rot [3][3];

    rej_front #(.W(WORD_BITS), .F(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_in_valid),
        .i_pos   (in_pos),
        .i_quat  (in_quat),
        .i_pt    (in_pt),
        .o_valid (f_valid),
        .o_cp    (f_cp),
        .o_rot   (f_rot)
    );

    logic [PW-1:0]       pay_in;
    logic [PW-1:0]       pay_out;
    logic                d_valid;
    logic signed [W-1:0] d_iz;
    logic                d_bad;
    logic signed [W-1:0] d_cp  [3];
    logic signed [W-1:0] d_rot [3][3];

    // cp and R ride alongside the divider
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pay_in[i*W +: W] = f_cp[i];
            d_cp[i]          = pay_out[i*W +: W];
            for (int j = 0; j < 3; j++) begin
                pay_in[(3+3*i+j)*W +: W] = f_rot[i][j];
                d_rot[i][j]              = pay_out[(3+3*i+j)*W +: W];
            end
        end
    end

    rej_recip #(.W(WORD_BITS), .F(FRAC_BITS), .PW(PW)) u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (f_valid),
        .i_z       (f_cp[2]),
        .i_payload (pay_in),
        .o_valid   (d_valid),
        .o_iz      (d_iz),
        .o_bad     (d_bad),
        .o_payload (pay_out)
    );

    logic signed [W-1:0] obs [2];
    logic                b_valid;
    logic                b_bad;
    logic signed [W-1:0] b_res  [2];
    logic signed [W-1:0] b_dpos [2][3];
    logic signed [W-1:0] b_drot [2][3];
    logic signed [W-1:0] b_dpt  [2][3];

    assign obs = '{r_obs_u, r_obs_v};

    rej_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (d_valid),
        .i_iz    (d_iz),
        .i_bad   (d_bad),
        .i_cp    (d_cp),
        .i_rot   (d_rot),
        .i_obs   (obs),
        .o_valid (b_valid),
        .o_bad   (b_bad),
        .o_res   (b_res),
        .o_dpos  (b_dpos),
        .o_drot  (b_drot),
        .o_dpt   (b_dpt)
    );

    // the last stage empties once its v row beat is taken
    assign out_take = b_valid && !i_out_stall;
    assign adv      = !b_valid || (r_row && !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 1'b0;
        end else if (out_take) begin
            r_row <= !r_row;
        end
    end

    assign o_in_stall  = !adv;
    assign o_out_valid = b_valid;
    assign o_last_row  = r_row;
    assign o_bad_depth = b_bad;
    assign o_residual  = b_res[r_row];
    assign o_d_pos_x   = b_dpos[r_row][0];
    assign o_d_pos_y   = b_dpos[r_row][1];
    assign o_d_pos_z   = b_dpos[r_row][2];
    assign o_d_rot_x   = b_drot[r_row][0];
    assign o_d_rot_y   = b_drot[r_row][1];
    assign o_d_rot_z   = b_drot[r_row][2];
    assign o_d_point_x = b_dpt[r_row][0];
    assign o_d_point_y = b_dpt[r_row][1];
    assign o_d_point_z = b_dpt[r_row][2];

    `RJ_ASSERT_NEXT(a_v_row_follows, i_clk, i_rst_n, out_take && !r_row, o_out_valid && r_row)
    `RJ_ASSERT_NEXT(a_bad_same_rows, i_clk, i_rst_n, out_take && !r_row, o_bad_depth == $past(o_bad_depth))
    `RJ_ASSERT(a_empty_accepts, i_clk, i_rst_n, !o_out_valid |-> !o_in_stall)

endmodule

/* tb/sv/reprojection_error_jacobian_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reprojection_error_jacobian_test
// self-checking bench for the residual and jacobian row pipeline
// ----------------------------------------------------------------------------
// a directed table then random poses and points are pushed through the block
// under several observation settings; every accepted input beat is run
// through a fixed-point predictor and both result rows are compared field by
// field with the beats leaving the block. both sides idle and stall at
// random, the receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module reprojection_error_jacobian_test;
    import rej_pkg::*;

    localparam int     WB       = 32;
    localparam int     FB       = 16;
    localparam longint WORD_MAX = 64'sh7fff_ffff;
    localparam longint WORD_MIN = -WORD_MAX - 1;
    localparam longint ONE      = 64'sd65536;
    localparam int     NFIELDS  = 10;
    localparam logic [CFG_IDX_BITS-1:0] SPARE_IDX = 2'd2;

    typedef longint t_pose_pt [NFIELDS];

    typedef struct {
        bit     last;
        bit     bad;
        longint v [NFIELDS];
    } t_row;

    typedef struct {
        t_pose_pt f;
        bit       known;
        bit       bad;
        longint   res_u;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [WB-1:0]      i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [WB-1:0] in_word [NFIELDS];
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_last_row;
    logic               o_bad_depth;
    logic signed [WB-1:0] out_word [NFIELDS];

    longint obs_u_q, obs_v_q;
    t_row   rows_due [$];
    int     mismatches, beats_in, rows_seen, bad_rows;
    int     hold_left;
    bit     hold_req;
    bit     hold_done;
    bit     quiet;

    string  fname [NFIELDS] = '{"residual", "d_pos_x", "d_pos_y", "d_pos_z", "d_rot_x",
                                "d_rot_y", "d_rot_z", "d_point_x", "d_point_y", "d_point_z"};

    reprojection_error_jacobian dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_pos_x(in_word[0]), .i_pos_y(in_word[1]), .i_pos_z(in_word[2]),
        .i_quat_x(in_word[3]), .i_quat_y(in_word[4]), .i_quat_z(in_word[5]),
        .i_quat_w(in_word[6]),
        .i_point_x(in_word[7]), .i_point_y(in_word[8]), .i_point_z(in_word[9]),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_last_row(o_last_row), .o_bad_depth(o_bad_depth),
        .o_residual(out_word[0]),
        .o_d_pos_x(out_word[1]), .o_d_pos_y(out_word[2]), .o_d_pos_z(out_word[3]),
        .o_d_rot_x(out_word[4]), .o_d_rot_y(out_word[5]), .o_d_rot_z(out_word[6]),
        .o_d_point_x(out_word[7]), .o_d_point_y(out_word[8]), .o_d_point_z(out_word[9])
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- fixed-point predictor ----------------
    function automatic longint clip(input longint v);
        return v > WORD_MAX ? WORD_MAX : (v < WORD_MIN ? WORD_MIN : v);
    endfunction

    function automatic longint qadd(input longint a, input longint b);
        return clip(a + b);
    endfunction

    function automatic longint qsub(input longint a, input longint b);
        return clip(a - b);
    endfunction

    // product floors toward minus infinity
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip(p >>> FB);
    endfunction

    function automatic longint inv_depth(input longint z, output bit bad);
        longint q, lim;
        bad = 1'b0;
        if (z == 0) begin
            bad = 1'b1;
            return WORD_MAX;
        end
        q   = (64'sd1 <<< (2 * FB)) / (z < 0 ? -z : z);
        lim = z < 0 ? WORD_MAX + 1 : WORD_MAX;
        if (q > lim) begin
            bad = 1'b1;
            q   = lim;
        end
        return z < 0 ? -q : q;
    endfunction

    task automatic predict_rows(input t_pose_pt f, input bit known, input bit kbad,
                                input longint kres);
        longint rot [3][3];
        longint dv [3], cam [3], h [3], a [3];
        longint tx, ty, tz, twx, twy, twz, txx, txy, txz, tyy, tyz, tzz;
        longint iz, proj, obs;
        bit     bad;
        t_row   r;
        for (int i = 0; i < 3; i++) dv[i] = qsub(f[7 + i], f[i]);
        tx  = qadd(f[3], f[3]);  ty  = qadd(f[4], f[4]);  tz  = qadd(f[5], f[5]);
        twx = qmul(tx, f[6]);    twy = qmul(ty, f[6]);    twz = qmul(tz, f[6]);
        txx = qmul(tx, f[3]);    txy = qmul(ty, f[3]);    txz = qmul(tz, f[3]);
        tyy = qmul(ty, f[4]);    tyz = qmul(tz, f[4]);    tzz = qmul(tz, f[5]);
        rot[0][0] = qsub(ONE, qadd(tyy, tzz));
        rot[0][1] = qsub(txy, twz);
        rot[0][2] = qadd(txz, twy);
        rot[1][0] = qadd(txy, twz);
        rot[1][1] = qsub(ONE, qadd(txx, tzz));
        rot[1][2] = qsub(tyz, twx);
        rot[2][0] = qsub(txz, twy);
        rot[2][1] = qadd(tyz, twx);
        rot[2][2] = qsub(ONE, qadd(txx, tyy));
        // camera frame point: transpose of the rotation applied to p - t
        for (int i = 0; i < 3; i++) begin
            cam[i] = 0;
            for (int j = 0; j < 3; j++) cam[i] = qadd(cam[i], qmul(rot[j][i], dv[j]));
        end
        iz = inv_depth(cam[2], bad);
        for (int rr = 0; rr < 2; rr++) begin
            proj = qmul(cam[rr], iz);
            obs  = rr == 0 ? obs_u_q : obs_v_q;
            h[0] = rr == 0 ? iz : 0;
            h[1] = rr == 1 ? iz : 0;
            h[2] = clip(-qmul(proj, iz));
            for (int i = 0; i < 3; i++) begin
                a[i] = 0;
                for (int j = 0; j < 3; j++) a[i] = qadd(a[i], qmul(h[j], rot[i][j]));
            end
            r.last = rr[0];
            r.bad  = known ? kbad : bad;
            r.v[0] = (known && rr == 0) ? kres : qsub(proj, obs);
            for (int i = 0; i < 3; i++) begin
                r.v[1 + i] = clip(-a[i]);
                r.v[7 + i] = a[i];
            end
            r.v[4] = qsub(qmul(h[1], cam[2]), qmul(h[2], cam[1]));
            r.v[5] = qsub(qmul(h[2], cam[0]), qmul(h[0], cam[2]));
            r.v[6] = qsub(qmul(h[0], cam[1]), qmul(h[1], cam[0]));
            rows_due.push_back(r);
        end
    endtask

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        t_row e;
        bit   bad_row;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            rows_seen++;
            if (o_bad_depth) bad_rows++;
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
            end else begin
                e = rows_due.pop_front();
                bad_row = (o_last_row !== e.last) || (o_bad_depth !== e.bad);
                for (int i = 0; i < NFIELDS; i++)
                    if (longint'(out_word[i]) !== e.v[i]) bad_row = 1'b1;
                if (bad_row) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: last %0d/%0d bad %0d/%0d (exp/got)",
                                 $realtime, e.last, o_last_row, e.bad, o_bad_depth);
                        for (int i = 0; i < NFIELDS; i++)
                            if (longint'(out_word[i]) !== e.v[i])
                                $display("  %s exp %0d got %0d", fname[i], e.v[i],
                                         longint'(out_word[i]));
                    end
                end
            end
        end
    end

    // receiver: random stalls, quiet stretches and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= 300;
            hold_done   <= 1'b1;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 8);
        end
    end

    // ---------------- sender side ----------------
    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input longint val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[WB-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_OBS_U) obs_u_q = longint'($signed(val[WB-1:0]));
        else if (idx == CFG_OBS_V) obs_v_q = longint'($signed(val[WB-1:0]));
    endtask

    task automatic send_beat(input t_pose_pt f, input bit known, input bit kbad,
                             input longint kres);
        if (!quiet && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        for (int i = 0; i < NFIELDS; i++) in_word[i] <= f[i][WB-1:0];
        do @(posedge i_clk); while (o_in_stall);
        beats_in++;
        predict_rows(f, known, kbad, kres);
    endtask

    // lower valid and wait until the pipe is empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (2 * FB + 20) @(posedge i_clk);
    endtask

    function automatic longint pick_word(input int mode);
        longint corner [6] = '{0, 1, -1, WORD_MAX, WORD_MIN, ONE};
        case (mode)
            0: return longint'($signed($urandom()));
            1: return corner[$urandom_range(5)];
            default: return longint'($urandom_range(2 * ONE)) - ONE;
        endcase
    endfunction

    // mostly plausible poses in front of the camera, some raw noise
    function automatic t_pose_pt random_item();
        t_pose_pt f;
        int sel;
        sel = $urandom_range(99);
        for (int i = 0; i < NFIELDS; i++) begin
            if (sel < 15) f[i] = pick_word(0);
            else if (sel < 27) f[i] = pick_word($urandom_range(1, 2));
            else f[i] = pick_word(2) * (i < 3 || i > 6 ? 8 : 1);
        end
        if (sel >= 27) f[9] = f[2] + longint'($urandom_range(20 * ONE, ONE / 16));
        return f;
    endfunction

    t_stim_row stim_tab [] = '{
        // identity pose, point one unit ahead: clean projection at the centre
        '{'{0, 0, 0, 0, 0, 0, ONE, 0, 0, ONE}, 1'b1, 1'b0, 0},
        // zero depth
        '{'{0, 0, 0, 0, 0, 0, ONE, 0, 0, 0}, 1'b1, 1'b1, 0},
        // tiny depths whose reciprocal overflows
        '{'{0, 0, 0, 0, 0, 0, ONE, 0, 0, 1}, 1'b1, 1'b1, 0},
        '{'{0, 0, 0, 0, 0, 0, ONE, 0, 0, -1}, 1'b1, 1'b1, 0},
        '{'{0, 0, 0, 0, 0, 0, ONE, 0, 0, 2}, 1'b1, 1'b1, 0},
        // negative depth just fitting the most negative word
        '{'{0, 0, 0, 0, 0, 0, ONE, 0, 0, -2}, 1'b1, 1'b0, 0},
        '{'{0, 0, 0, 0, 0, 0, ONE, 0, 0, 3}, 1'b0, 1'b0, 0},
        '{'{0, 0, 0, 0, 0, 0, ONE, ONE, -ONE, 2 * ONE}, 1'b0, 1'b0, 0},
        '{'{ONE, 2 * ONE, -3 * ONE, 0, 0, 46341, 46341, 5 * ONE, ONE, 4 * ONE},
           1'b0, 1'b0, 0},
        // non-unit and zero quaternions
        '{'{0, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE}, 1'b0, 1'b0, 0},
        '{'{0, 0, 0, 3 * ONE, -2 * ONE, ONE, 5 * ONE, ONE, 2 * ONE, 7 * ONE},
           1'b0, 1'b0, 0},
        // field extremes and saturating differences
        '{'{WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, ONE, WORD_MAX, WORD_MAX, WORD_MAX},
           1'b0, 1'b0, 0},
        '{'{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
            WORD_MAX, WORD_MAX, WORD_MAX}, 1'b0, 1'b0, 0},
        '{'{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
            WORD_MIN, WORD_MIN, WORD_MIN}, 1'b0, 1'b0, 0},
        '{'{WORD_MAX, WORD_MIN, 0, WORD_MIN, WORD_MAX, -1, 1, WORD_MIN, WORD_MAX, -1},
           1'b0, 1'b0, 0},
        '{'{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1}, 1'b0, 1'b0, 0},
        '{'{0, 0, ONE, 0, ONE, 0, 0, 0, 0, 0}, 1'b0, 1'b0, 0}
    };

    initial begin
        longint obs_set [5][2] = '{'{WORD_MAX, WORD_MIN}, '{WORD_MIN, WORD_MAX},
                                   '{ONE, -ONE}, '{0, 0}, '{-1, 1}};
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_OBS_U;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        for (int i = 0; i < NFIELDS; i++) in_word[i] <= '0;
        obs_u_q = 0; obs_v_q = 0;
        mismatches = 0; beats_in = 0; rows_seen = 0; bad_rows = 0;
        hold_req = 1'b0; quiet = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // observations sit at their reset value of zero for the table
        foreach (stim_tab[k])
            send_beat(stim_tab[k].f, stim_tab[k].known, stim_tab[k].bad, stim_tab[k].res_u);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 3) begin
                obs_set[ph][0] = longint'($signed($urandom()));
                obs_set[ph][1] = longint'($signed($urandom()));
            end
            cfg_write(CFG_OBS_U, obs_set[ph][0]);
            cfg_write(CFG_OBS_V, obs_set[ph][1]);
            if (ph == 2) cfg_write(SPARE_IDX, longint'($urandom()));
            quiet = (ph == 4);
            for (int n = 0; n < 127; n++) begin
                // long hold-off so the pipe fills and pushes back on the input
                if (ph == 1 && n == 20) hold_req = 1'b1;
                send_beat(random_item(), 1'b0, 1'b0, 0);
            end
            drain();
        end

        $display("%0d input beats, %0d rows checked (%0d with saturated depth)",
                 beats_in, rows_seen, bad_rows);
        $display("six observation settings incl. both extremes, long output hold-off");
        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatching beats", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout with %0d rows still due", rows_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* reprojection_error_jacobian.f */
+incdir+src
src/rej_pkg.sv
src/rej_fmul.sv
src/rej_front.sv
src/rej_recip.sv
src/rej_back.sv
src/reprojection_error_jacobian.sv
tb/sv/reprojection_error_jacobian_test.sv
